/* src/ping_pong_row_reorder_width_split_assert.svh */
// Assertion macros shared by the row reorder RTL.
`ifndef PING_PONG_ROW_REORDER_WIDTH_SPLIT_ASSERT_SVH
`define PING_PONG_ROW_REORDER_WIDTH_SPLIT_ASSERT_SVH

// Implication checked on every rising edge of clk outside reset.
`define PPRW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising edge of clk outside reset.
`define PPRW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pprw_pkg.sv */
// Shared types and constants for the ping-pong row reorder block.
`timescale 1ns / 1ps
package pprw_pkg;

    localparam int COLS        = 10;
    localparam int HALF        = 5;
    localparam int FIELD_WIDTH = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [FIELD_WIDTH-1:0] field_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

    // One bank event: a filled bank handed on, or a drained bank handed back.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_msg_t;

endpackage

/* src/pprw_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pprw_ram #(
    parameter int WIDTH = 320,
    parameter int DEPTH = 20
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/pprw_front.sv */
// Front end: accepts rows, writes them bottom-up into the fill bank, hands full banks on.
`timescale 1ns / 1ps
`include "ping_pong_row_reorder_width_split_assert.svh"
module pprw_front #(
    parameter int ROWS       = 10,
    parameter int DATA_WIDTH = 32,
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int AW = $clog2(2 * ROWS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pprw_pkg::field_t                  lanes [pprw_pkg::COLS],
    input  pprw_pkg::bank_msg_t               release_in,
    output logic                              we,
    output logic [AW-1:0]                     waddr,
    output logic [pprw_pkg::COLS*DATA_WIDTH-1:0] wdata,
    output pprw_pkg::bank_msg_t               push
);

    logic [RW-1:0] fill_row_reg;
    logic [RW-1:0] fill_row_next;
    logic          fill_bank_reg;
    logic          fill_bank_next;
    logic [1:0]    full_reg;
    logic [1:0]    full_next;
    logic          accept;
    logic          row_last;

    // Stall while the bank to fill is still queued or draining
    assign busy     = full_reg[fill_bank_reg];
    assign accept   = start && !busy;
    assign row_last = (fill_row_reg == '0);

    // Row write into the fill bank; bank b occupies rows b*ROWS .. b*ROWS+ROWS-1
    assign we    = accept;
    assign waddr = fill_bank_reg ? (AW'(ROWS) + AW'(fill_row_reg)) : AW'(fill_row_reg);

    always_comb
    begin
        for (int c = 0; c < pprw_pkg::COLS; c++)
        begin
            wdata[c*DATA_WIDTH +: DATA_WIDTH] = DATA_WIDTH'(lanes[c]);
        end
    end

    // Hand the bank on when its top row lands
    assign push.valid = accept && row_last;
    assign push.bank  = fill_bank_reg;

    // Advance fill position and bank ownership
    always_comb
    begin
        fill_row_next  = fill_row_reg;
        fill_bank_next = fill_bank_reg;
        full_next      = full_reg;
        if (accept)
        begin
            if (row_last)
            begin
                fill_row_next  = RW'(ROWS - 1);
                fill_bank_next = !fill_bank_reg;
            end
            else
            begin
                fill_row_next = fill_row_reg - 1'b1;
            end
        end
        if (release_in.valid)
        begin
            full_next[release_in.bank] = 1'b0;
        end
        if (push.valid)
        begin
            full_next[push.bank] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_row_reg  <= RW'(ROWS - 1);
            fill_bank_reg <= 1'b0;
            full_reg      <= '0;
        end
        else
        begin
            fill_row_reg  <= fill_row_next;
            fill_bank_reg <= fill_bank_next;
            full_reg      <= full_next;
        end
    end

    `PPRW_ASSERT_IMP(a_release_of_full_bank, release_in.valid, full_reg[release_in.bank], "bank released while not full")

endmodule

/* src/pprw_queue.sv */
// Short queue of filled bank numbers between front and back.
`timescale 1ns / 1ps
`include "ping_pong_row_reorder_width_split_assert.svh"
module pprw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  pprw_pkg::bank_msg_t push,
    input  logic                pop,
    output logic                not_empty,
    output logic                head
);

    localparam int CW = $clog2(pprw_pkg::QUEUE_DEPTH + 1);
    localparam int IW = (pprw_pkg::QUEUE_DEPTH > 1) ? $clog2(pprw_pkg::QUEUE_DEPTH) : 1;

    logic          slot_reg  [pprw_pkg::QUEUE_DEPTH];
    logic          slot_next [pprw_pkg::QUEUE_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] widx;

    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[0];

    // Shift on pop, append behind the last live entry on push
    always_comb
    begin
        slot_next = slot_reg;
        if (pop)
        begin
            for (int i = 0; i < pprw_pkg::QUEUE_DEPTH - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
        end
        widx = pop ? (count_reg - 1'b1) : count_reg;
        if (push.valid)
        begin
            slot_next[widx[IW-1:0]] = push.bank;
        end
        count_next = count_reg - CW'(pop) + CW'(push.valid);
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `PPRW_ASSERT_IMP(a_no_overflow, push.valid && !pop, count_reg != CW'(pprw_pkg::QUEUE_DEPTH), "queue push while full")
    `PPRW_ASSERT_IMP(a_no_underflow, pop, count_reg != '0, "queue pop while empty")

endmodule

/* src/pprw_back.sv */
// Back end: drains a full bank row by row as left and right half-row beats.
`timescale 1ns / 1ps
`include "ping_pong_row_reorder_width_split_assert.svh"
module pprw_back #(
    parameter int ROWS       = 10,
    parameter int DATA_WIDTH = 32,
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int AW = $clog2(2 * ROWS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  logic                                 q_bank,
    output logic                                 pop,
    output logic                                 re,
    output logic [AW-1:0]                        raddr,
    input  logic [pprw_pkg::COLS*DATA_WIDTH-1:0] rdata,
    output pprw_pkg::bank_msg_t                  release_out,
    output logic                                 valid,
    output pprw_pkg::field_t                     words [pprw_pkg::HALF],
    output logic                                 block_end
);

    pprw_pkg::back_state_t state_reg;
    pprw_pkg::back_state_t state_next;
    logic          bank_reg;
    logic          bank_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          half_reg;
    logic          half_next;
    logic          out_valid_reg;
    logic          out_half_reg;
    logic          out_last_reg;
    logic          last_beat;

    assign last_beat = (row_reg == RW'(ROWS - 1)) && half_reg;

    // Read address of the current row within the draining bank
    assign raddr = bank_reg ? (AW'(ROWS) + AW'(row_reg)) : AW'(row_reg);

    // Next state, beat position and queue pop
    always_comb
    begin
        state_next        = state_reg;
        bank_next         = bank_reg;
        row_next          = row_reg;
        half_next         = half_reg;
        pop               = 1'b0;
        re                = 1'b0;
        release_out.valid = 1'b0;
        release_out.bank  = bank_reg;
        unique case (state_reg)
            pprw_pkg::BACK_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    state_next = pprw_pkg::BACK_RUN;
                    bank_next  = q_bank;
                    row_next   = '0;
                    half_next  = 1'b0;
                end
            end
            pprw_pkg::BACK_RUN:
            begin
                re = 1'b1;
                if (last_beat)
                begin
                    release_out.valid = 1'b1;
                    if (q_valid)
                    begin
                        pop       = 1'b1;
                        bank_next = q_bank;
                        row_next  = '0;
                        half_next = 1'b0;
                    end
                    else
                    begin
                        state_next = pprw_pkg::BACK_IDLE;
                    end
                end
                else
                begin
                    half_next = !half_reg;
                    if (half_reg)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = pprw_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pprw_pkg::BACK_IDLE;
            bank_reg      <= 1'b0;
            row_reg       <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_half_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            row_reg       <= row_next;
            half_reg      <= half_next;
            out_valid_reg <= (state_reg == pprw_pkg::BACK_RUN);
            out_half_reg  <= half_reg;
            out_last_reg  <= last_beat;
        end
    end

    // Select the half row and sign-extend each word to the field width
    always_comb
    begin
        int base;
        base = out_half_reg ? pprw_pkg::HALF : 0;
        for (int j = 0; j < pprw_pkg::HALF; j++)
        begin
            words[j] = pprw_pkg::FIELD_WIDTH'(signed'(rdata[(base + j)*DATA_WIDTH +: DATA_WIDTH]));
        end
    end

    assign valid     = out_valid_reg;
    assign block_end = out_valid_reg && out_last_reg;

    `PPRW_ASSERT_IMP(a_valid_after_run, valid, $past(state_reg == pprw_pkg::BACK_RUN), "beat without a read")
    `PPRW_ASSERT_NEXT(a_block_contiguous, valid && !block_end, valid, "gap inside a block")

endmodule

/* src/ping_pong_row_reorder_width_split.sv */
// Top level of the ping-pong row reorder with half-row output split.
//
//  channel   ports                          transfer
//  -------   -----------------------------  -----------------------------------
//  input     start, busy, lane_0..lane_9    at a rising edge with start && !busy
//  output    valid, out_0..out_4, block_end at a rising edge with valid high
//
// An input row is taken whenever the bank being filled is free.
// A full block of ROWS rows leaves as 2*ROWS consecutive beats, one per cycle.
// With the back end idle, the first beat passes the queue register, the state
// register and the RAM read register after the edge that takes the last row;
// otherwise it follows the previous block's last beat. Each beat reads its row
// once more, and each row leaves as two beats.
// busy is high while the bank to fill next still waits in the queue or drains.
// Reset drops a partly gathered block; the banks need no clearing pass.
// The receiver cannot stall: each beat is shown for exactly one cycle.
`timescale 1ns / 1ps
module ping_pong_row_reorder_width_split #(
    parameter int ROWS       = 10,
    parameter int DATA_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic signed [31:0] lane_0,
    input  logic signed [31:0] lane_1,
    input  logic signed [31:0] lane_2,
    input  logic signed [31:0] lane_3,
    input  logic signed [31:0] lane_4,
    input  logic signed [31:0] lane_5,
    input  logic signed [31:0] lane_6,
    input  logic signed [31:0] lane_7,
    input  logic signed [31:0] lane_8,
    input  logic signed [31:0] lane_9,
    output logic             valid,
    output logic signed [31:0] out_0,
    output logic signed [31:0] out_1,
    output logic signed [31:0] out_2,
    output logic signed [31:0] out_3,
    output logic signed [31:0] out_4,
    output logic             block_end
);

    localparam int AW    = $clog2(2 * ROWS);
    localparam int WIDTH = pprw_pkg::COLS * DATA_WIDTH;

    pprw_pkg::field_t    lanes [pprw_pkg::COLS];
    pprw_pkg::field_t    words [pprw_pkg::HALF];
    pprw_pkg::bank_msg_t push;
    pprw_pkg::bank_msg_t release_msg;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [WIDTH-1:0]    wdata;
    logic                re;
    logic [AW-1:0]       raddr;
    logic [WIDTH-1:0]    rdata;
    logic                pop;
    logic                q_valid;
    logic                q_bank;

    // Gather the input row
    assign lanes[0] = lane_0;
    assign lanes[1] = lane_1;
    assign lanes[2] = lane_2;
    assign lanes[3] = lane_3;
    assign lanes[4] = lane_4;
    assign lanes[5] = lane_5;
    assign lanes[6] = lane_6;
    assign lanes[7] = lane_7;
    assign lanes[8] = lane_8;
    assign lanes[9] = lane_9;

    pprw_front #(
        .ROWS       (ROWS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .lanes      (lanes),
        .release_in (release_msg),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .push       (push)
    );

    pprw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_bank)
    );

    // Both banks share one row-wide store
    pprw_ram #(
        .WIDTH (WIDTH),
        .DEPTH (2 * ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    pprw_back #(
        .ROWS       (ROWS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_bank      (q_bank),
        .pop         (pop),
        .re          (re),
        .raddr       (raddr),
        .rdata       (rdata),
        .release_out (release_msg),
        .valid       (valid),
        .words       (words),
        .block_end   (block_end)
    );

    // Spread the half row onto the result ports
    assign out_0 = words[0];
    assign out_1 = words[1];
    assign out_2 = words[2];
    assign out_3 = words[3];
    assign out_4 = words[4];

endmodule

/* bench/tb.sv */
// Self-checking testbench for the ping-pong row reorder with half-row output split.
`timescale 1ns / 1ps
module tb;

    localparam int BLOCK_ROWS = 10;
    localparam int BEATS      = 2 * BLOCK_ROWS;
    localparam int RAND_ROWS  = 450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef logic [0:pprw_pkg::COLS-1][31:0] row_words_t;
    typedef logic [0:pprw_pkg::HALF-1][31:0] half_words_t;

    // One expected output transfer
    typedef struct packed {
        half_words_t word;
        logic        last;
    } beat_t;

    // Directed row: lane c carries base + c * stride
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] stride;
        logic [7:0]  gap;
        logic        typed;
        half_words_t first;
    } row_cmd_t;

    localparam row_cmd_t DIR_ROWS [20] = '{
        '{32'h0000_0000, 32'h0000_0000, 8'd0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 8'd1, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h0000_0000, 8'd0, 1'b0, '0},
        '{32'h8000_0000, 32'h0000_0000, 8'd3, 1'b0, '0},
        '{32'hAAAA_AAAA, 32'h0000_0000, 8'd0, 1'b0, '0},
        '{32'h5555_5555, 32'h0000_0000, 8'd0, 1'b0, '0},
        '{32'h0000_0000, 32'h0000_0001, 8'd2, 1'b0, '0},
        '{32'h7FFF_FFFB, 32'h0000_0001, 8'd0, 1'b0, '0},
        '{32'hFFFF_FFFE, 32'h0000_0001, 8'd0, 1'b0, '0},
        '{32'h8000_0000, 32'hFFFF_FFFF, 8'd0, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFC}},
        // second block fills back to back while the first one drains
        '{32'h1234_5678, 32'h1111_1111, 8'd0, 1'b0, '0},
        '{32'hDEAD_BEEF, 32'h0101_0101, 8'd0, 1'b0, '0},
        '{32'h0000_0001, 32'h0000_0001, 8'd0, 1'b0, '0},
        '{32'hFFFF_FF00, 32'h0000_0010, 8'd0, 1'b0, '0},
        '{32'h7FFF_FFF0, 32'h0000_0004, 8'd0, 1'b0, '0},
        '{32'h0F0F_0F0F, 32'hF0F0_F0F0, 8'd0, 1'b0, '0},
        '{32'h8000_0001, 32'h8000_0000, 8'd0, 1'b0, '0},
        '{32'h3C3C_3C3C, 32'h0000_0000, 8'd0, 1'b0, '0},
        '{32'hC3C3_C3C3, 32'hFFFF_FFFE, 8'd0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 8'd0, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}}
    };

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    row_words_t lane_drv;
    logic signed [31:0] out_0, out_1, out_2, out_3, out_4;
    logic valid;
    logic block_end;

    // Typed first beat that rides along with the row driven onto the input ports
    logic        first_typed;
    half_words_t first_exp;

    // Predictor state: two banks of rows, fill pointer and bank select
    row_words_t bank [2][BLOCK_ROWS];
    int         fill_row;
    logic       fill_sel;
    beat_t      beats_due [$];

    int mismatches;
    int cycle_count;

    ping_pong_row_reorder_width_split dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .lane_0    (lane_drv[0]),
        .lane_1    (lane_drv[1]),
        .lane_2    (lane_drv[2]),
        .lane_3    (lane_drv[3]),
        .lane_4    (lane_drv[4]),
        .lane_5    (lane_drv[5]),
        .lane_6    (lane_drv[6]),
        .lane_7    (lane_drv[7]),
        .lane_8    (lane_drv[8]),
        .lane_9    (lane_drv[9]),
        .valid     (valid),
        .out_0     (out_0),
        .out_1     (out_1),
        .out_2     (out_2),
        .out_3     (out_3),
        .out_4     (out_4),
        .block_end (block_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Store one accepted row; a completed bank turns into twenty half-row beats
    task automatic store_row(input row_words_t words, input logic typed,
                             input half_words_t first);
        beat_t b;
        int    r;
        int    j;
        bank[fill_sel][fill_row] = words;
        if (fill_row != 0)
        begin
            fill_row--;
        end
        else
        begin
            for (r = 0; r < BEATS; r++)
            begin
                for (j = 0; j < pprw_pkg::HALF; j++)
                    b.word[j] = bank[fill_sel][r / 2][(r % 2) * pprw_pkg::HALF + j];
                b.last = (r == BEATS - 1);
                if (typed && r == 0)
                    b.word = first;
                beats_due.push_back(b);
            end
            fill_row = BLOCK_ROWS - 1;
            fill_sel = ~fill_sel;
        end
    endtask

    // Compare one output transfer with the oldest pending beat
    task automatic check_beat();
        beat_t       b;
        half_words_t got;
        got = '{out_0, out_1, out_2, out_3, out_4};
        if (beats_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("tb: unexpected beat %h %h %h %h %h end %b",
                         got[0], got[1], got[2], got[3], got[4], block_end);
        end
        else
        begin
            b = beats_due.pop_front();
            if (got !== b.word || block_end !== b.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: beat mismatch: exp %h %h %h %h %h end %b, got %h %h %h %h %h end %b",
                             b.word[0], b.word[1], b.word[2], b.word[3], b.word[4], b.last,
                             got[0], got[1], got[2], got[3], got[4], block_end);
            end
        end
    endtask

    // Sample both channels at the rising edge: outputs first, then input transfer
    always @(posedge clk)
    begin
        if (rst_n && valid === 1'b1)
            check_beat();
        if (rst_n && start && busy === 1'b0)
            store_row(lane_drv, first_typed, first_exp);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic row_words_t pick_row();
        row_words_t w;
        int         c;
        for (c = 0; c < pprw_pkg::COLS; c++)
            w[c] = pick_word();
        return w;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // Present one row, hold it until the transfer, then idle for the given gap
    task automatic send_row(input row_words_t words, input int gap, input logic typed,
                            input half_words_t first);
        @(negedge clk);
        lane_drv    = words;
        first_typed = typed;
        first_exp   = first;
        start       = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (gap > 0)
        begin
            @(negedge clk);
            start    = 1'b0;
            lane_drv = pick_row();
            repeat (gap - 1)
            begin
                @(negedge clk);
                lane_drv = pick_row();
            end
        end
    endtask

    initial
    begin
        row_words_t words;
        int         i;
        int         c;
        bit         burst;

        rst_n       = 1'b0;
        start       = 1'b0;
        lane_drv    = '0;
        first_typed = 1'b0;
        first_exp   = '0;
        fill_row    = BLOCK_ROWS - 1;
        fill_sel    = 1'b0;
        mismatches  = 0;
        cycle_count = 0;

        // Hold reset, then release it away from the rising edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        for (i = 0; i < $size(DIR_ROWS); i++)
        begin
            for (c = 0; c < pprw_pkg::COLS; c++)
                words[c] = DIR_ROWS[i].base + c * DIR_ROWS[i].stride;
            send_row(words, DIR_ROWS[i].gap, DIR_ROWS[i].typed, DIR_ROWS[i].first);
        end

        // Random blocks; some go through without any idle cycle
        burst = 1'b0;
        for (i = 0; i < RAND_ROWS; i++)
        begin
            if (i % BLOCK_ROWS == 0)
                burst = ($urandom_range(3) == 0);
            send_row(pick_row(), burst ? 0 : pick_gap(), 1'b0, '0);
        end

        @(negedge clk);
        start = 1'b0;

        // Drain, then allow the block's latency to pass
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (2 * BEATS) @(posedge clk);

        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
